// ===== src/afq_pkg.sv =====
`default_nettype none
package afq_pkg;

	localparam int QUO_BITS = 26;

	localparam logic [1:0] REG_SCALE  = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_SIGNED = 2'd3;

	typedef enum logic [1:0] {
		KIND_FIN,
		KIND_NAN,
		KIND_HUGE,
		KIND_ZERO
	} kind_t;

	typedef struct packed {
		logic              sign;
		logic [23:0]       mant;
		logic signed [9:0] exp;
		logic              is_zero;
		logic              is_inf;
		logic              is_nan;
	} unp_t;

	typedef struct packed {
		logic [24:0]       rem;
		logic [25:0]       quo;
		logic [23:0]       mb;
		logic signed [9:0] exp;
		logic              sign;
		kind_t             kind;
		logic              last;
	} div_t;

	function automatic logic [4:0] lzc24(input logic [23:0] x);
		logic [4:0] n;
		logic       found;
		n = 5'd24;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && x[i]) begin
				n = 5'(23 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic unp_t unpack(input logic [31:0] b);
		unp_t       u;
		logic [4:0] lz;
		lz = lzc24({1'b0, b[22:0]});
		u.sign = b[31];
		u.is_zero = (b[30:0] == 31'd0);
		u.is_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		u.is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (b[30:23] == 8'd0) begin
			u.mant = {1'b0, b[22:0]} << lz;
			u.exp = -10'sd126 - $signed({5'd0, lz});
		end else begin
			u.mant = {1'b1, b[22:0]};
			u.exp = $signed({2'd0, b[30:23]}) - 10'sd127;
		end
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== src/afq_div_cell.sv =====
`default_nettype none
module afq_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire afq_pkg::div_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output afq_pkg::div_t      out_data
);

	logic          v_q;
	afq_pkg::div_t d_q;
	afq_pkg::div_t nxt;
	logic          ge;

	// one restoring quotient bit per cell
	always_comb begin
		nxt = in_data;
		ge = (in_data.rem >= {1'b0, in_data.mb});
		if (ge) begin
			nxt.rem = (in_data.rem - {1'b0, in_data.mb}) << 1;
		end else begin
			nxt.rem = in_data.rem << 1;
		end
		nxt.quo = {in_data.quo[24:0], ge};
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;

endmodule
`default_nettype wire

// ===== src/affine_float_to_int_quantizer.sv =====
// channel | dir | signals                              | contents
// s_      | in  | s_tvalid s_tready s_tdata s_tlast    | float32 sample, last marker
// m_      | out | m_tvalid m_tready m_tdata m_tuser m_tlast | quantized value, clamp flag
// apb     | in  | psel penable pwrite paddr pwdata ... | scale, zero point, width, mode
// One item per cycle while m_tready is high; stages: unpack, 26 divider cells
// (one quotient bit each), round, shift, add, saturate.
// Each stage holds its own valid; bubbles collapse, and s_tready falls only
// when every stage is full and m_tready is low.
// Reset clears all valid bits and loads scale 1.0, offset 0, width 8, signed.
`default_nettype none
module affine_float_to_int_quantizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value_bits
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] quant_value
	output logic [0:0]       m_tuser,   // [0] clamped
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int NQ = afq_pkg::QUO_BITS;

	logic [31:0] scale_q;
	logic [31:0] offset_q;
	logic [5:0]  width_q;
	logic        signed_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'h3F800000;
			offset_q <= 32'd0;
			width_q <= 6'd8;
			signed_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				afq_pkg::REG_SCALE:  scale_q <= pwdata;
				afq_pkg::REG_OFFSET: offset_q <= pwdata;
				afq_pkg::REG_WIDTH:  width_q <= pwdata[5:0];
				afq_pkg::REG_SIGNED: signed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			afq_pkg::REG_SCALE:  prdata = scale_q;
			afq_pkg::REG_OFFSET: prdata = offset_q;
			afq_pkg::REG_WIDTH:  prdata = {26'd0, width_q};
			afq_pkg::REG_SIGNED: prdata = {31'd0, signed_q};
			default:             prdata = 32'd0;
		endcase
	end

	// ready chain
	logic f_v_s0, r_v_s1, h_v_s2, a_v_s3, o_v_s4;
	logic f_rdy, r_rdy, h_rdy, a_rdy, o_rdy;
	logic [NQ:0]   c_v;
	logic [NQ:0]   c_r;
	afq_pkg::div_t c_d [NQ+1];

	assign o_rdy = !o_v_s4 || m_tready;
	assign a_rdy = !a_v_s3 || o_rdy;
	assign h_rdy = !h_v_s2 || a_rdy;
	assign r_rdy = !r_v_s1 || h_rdy;
	assign f_rdy = !f_v_s0 || c_r[0];
	assign s_tready = f_rdy;

	// unpack
	afq_pkg::unp_t ua, ub;
	afq_pkg::div_t f_nxt;
	afq_pkg::div_t f_s0;

	always_comb begin
		ua = afq_pkg::unpack(s_tdata);
		ub = afq_pkg::unpack(scale_q);
		f_nxt.rem = {1'b0, ua.mant};
		f_nxt.quo = '0;
		f_nxt.mb = ub.mant;
		f_nxt.exp = ua.exp - ub.exp;
		f_nxt.sign = ua.sign ^ ub.sign;
		f_nxt.last = s_tlast;
		if (ua.is_nan || ub.is_nan || (ua.is_zero && ub.is_zero) || (ua.is_inf && ub.is_inf)) begin
			f_nxt.kind = afq_pkg::KIND_NAN;
		end else if (ub.is_zero || ua.is_inf) begin
			f_nxt.kind = afq_pkg::KIND_HUGE;
		end else if (ua.is_zero || ub.is_inf) begin
			f_nxt.kind = afq_pkg::KIND_ZERO;
		end else begin
			f_nxt.kind = afq_pkg::KIND_FIN;
		end
		if (ub.is_zero) begin
			f_nxt.mb = 24'h800000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_s0 <= 1'b0;
		end else if (f_rdy) begin
			f_v_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (f_rdy && s_tvalid) begin
			f_s0 <= f_nxt;
		end
	end

	assign c_v[0] = f_v_s0;
	assign c_d[0] = f_s0;

	for (genvar i = 0; i < NQ; i++) begin : g_cell
		afq_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_v[i]),
			.in_ready  (c_r[i]),
			.in_data   (c_d[i]),
			.out_valid (c_v[i+1]),
			.out_ready (c_r[i+1]),
			.out_data  (c_d[i+1])
		);
	end
	assign c_r[NQ] = r_rdy;

	// round to nearest even
	afq_pkg::div_t     dq;
	logic [23:0]       rm;
	logic              rg, rst;
	logic signed [9:0] re;
	logic [24:0]       rm1;
	logic [23:0]       r_mant_s1, r_mant_nxt;
	logic signed [9:0] r_exp_s1, r_exp_nxt;
	logic              r_sign_s1, r_last_s1;
	afq_pkg::kind_t    r_kind_s1;

	always_comb begin
		dq = c_d[NQ];
		if (dq.quo[25]) begin
			rm = dq.quo[25:2];
			rg = dq.quo[1];
			rst = dq.quo[0] | (dq.rem != 25'd0);
			re = dq.exp;
		end else begin
			rm = dq.quo[24:1];
			rg = dq.quo[0];
			rst = (dq.rem != 25'd0);
			re = dq.exp - 10'sd1;
		end
		rm1 = {1'b0, rm} + {24'd0, rg & (rst | rm[0])};
		if (rm1[24]) begin
			r_mant_nxt = 24'h800000;
			r_exp_nxt = re + 10'sd1;
		end else begin
			r_mant_nxt = rm1[23:0];
			r_exp_nxt = re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_v_s1 <= 1'b0;
		end else if (r_rdy) begin
			r_v_s1 <= c_v[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (r_rdy && c_v[NQ]) begin
			r_mant_s1 <= r_mant_nxt;
			r_exp_s1 <= r_exp_nxt;
			r_sign_s1 <= dq.sign;
			r_kind_s1 <= dq.kind;
			r_last_s1 <= dq.last;
		end
	end

	// integer part
	logic [62:0]    sh;
	logic [39:0]    h_mag_s2, h_mag_nxt;
	afq_pkg::kind_t h_kind_s2, h_kind_nxt;
	logic           h_sign_s2, h_last_s2;

	always_comb begin
		sh = {39'd0, r_mant_s1} << r_exp_s1[5:0];
		h_mag_nxt = 40'd0;
		h_kind_nxt = r_kind_s1;
		if (r_kind_s1 == afq_pkg::KIND_ZERO) begin
			h_kind_nxt = afq_pkg::KIND_FIN;
		end else if (r_kind_s1 == afq_pkg::KIND_FIN) begin
			if (r_exp_s1 >= 10'sd40) begin
				h_kind_nxt = afq_pkg::KIND_HUGE;
			end else if (r_exp_s1 >= 10'sd0) begin
				h_mag_nxt = sh[62:23];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_v_s2 <= 1'b0;
		end else if (h_rdy) begin
			h_v_s2 <= r_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (h_rdy && r_v_s1) begin
			h_mag_s2 <= h_mag_nxt;
			h_kind_s2 <= h_kind_nxt;
			h_sign_s2 <= r_sign_s1;
			h_last_s2 <= r_last_s1;
		end
	end

	// zero point
	logic signed [41:0] smag;
	logic signed [41:0] a_sum_s3;
	afq_pkg::kind_t     a_kind_s3;
	logic               a_sign_s3, a_last_s3;

	always_comb begin
		smag = h_sign_s2 ? -$signed({2'd0, h_mag_s2}) : $signed({2'd0, h_mag_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_s3 <= 1'b0;
		end else if (a_rdy) begin
			a_v_s3 <= h_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (a_rdy && h_v_s2) begin
			a_sum_s3 <= smag + $signed({{10{offset_q[31]}}, offset_q});
			a_kind_s3 <= h_kind_s2;
			a_sign_s3 <= h_sign_s2;
			a_last_s3 <= h_last_s2;
		end
	end

	// saturate to the width range; NaN gives 0
	logic [5:0]         w;
	logic signed [41:0] hi, lo;
	logic [31:0]        o_val_nxt;
	logic               o_clamp_nxt;
	logic [31:0]        o_val_s4;
	logic               o_clamp_s4, o_last_s4;

	always_comb begin
		if (width_q == 6'd0) begin
			w = 6'd1;
		end else if (width_q > 6'd32) begin
			w = 6'd32;
		end else begin
			w = width_q;
		end
		if (signed_q) begin
			hi = (42'sd1 <<< (w - 6'd1)) - 42'sd1;
			lo = -hi - 42'sd1;
		end else begin
			hi = (42'sd1 <<< w) - 42'sd1;
			lo = 42'sd0;
		end
		o_val_nxt = a_sum_s3[31:0];
		o_clamp_nxt = 1'b0;
		case (a_kind_s3)
			afq_pkg::KIND_NAN: begin
				o_val_nxt = 32'd0;
			end
			afq_pkg::KIND_HUGE: begin
				o_val_nxt = a_sign_s3 ? lo[31:0] : hi[31:0];
				o_clamp_nxt = 1'b1;
			end
			default: begin
				if (a_sum_s3 > hi) begin
					o_val_nxt = hi[31:0];
					o_clamp_nxt = 1'b1;
				end else if (a_sum_s3 < lo) begin
					o_val_nxt = lo[31:0];
					o_clamp_nxt = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_s4 <= 1'b0;
		end else if (o_rdy) begin
			o_v_s4 <= a_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (o_rdy && a_v_s3) begin
			o_val_s4 <= o_val_nxt;
			o_clamp_s4 <= o_clamp_nxt;
			o_last_s4 <= a_last_s3;
		end
	end

	assign m_tvalid = o_v_s4;
	assign m_tdata = o_val_s4;
	assign m_tuser = o_clamp_s4;
	assign m_tlast = o_last_s4;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_round_norm: assert property (@(posedge clk) disable iff (!arst_n)
		r_v_s1 && r_kind_s1 == afq_pkg::KIND_FIN |-> r_mant_s1[23])
		else $error("rounded mantissa not normalized");

	a_unsigned_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && !signed_q && m_tdata != 32'd0 |-> m_tdata == hi[31:0])
		else $error("unsigned clamp value off range limit");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {QK_FIN, QK_NAN, QK_POS, QK_NEG} qkind_t;

	typedef struct packed {
		logic [31:0] qv;
		logic        clamp;
		logic        last;
	} quant_t;

	typedef struct packed {
		logic [31:0] scale;
		logic [31:0] offset;
		logic [5:0]  width;
		logic        sgn;
	} qcfg_t;

	class quant_scoreboard;
		logic [31:0] scale = 32'h3F800000;
		logic signed [31:0] offset = 0;
		logic [5:0] width = 6'd8;
		logic sgn = 1'b1;
		quant_t pending_q[$];
		int errors = 0;
		int checked = 0;
		int clamps = 0;

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				afq_pkg::REG_SCALE: begin
					scale = val;
				end
				afq_pkg::REG_OFFSET: begin
					offset = val;
				end
				afq_pkg::REG_WIDTH: begin
					width = val[5:0];
				end
				default: begin
					sgn = val[0];
				end
			endcase
		endfunction

		function quant_t quantize(logic [31:0] vb, logic last);
			quant_t r;
			int w, ea, eb, e;
			longint hi, lo, mag, sum, num, den, quo, rm;
			logic [24:0] ma, mb, mant;
			logic a_nan, b_nan, a_inf, b_inf, neg, rup;
			qkind_t kind;
			w = int'(width);
			if (w < 1) w = 1;
			if (w > 32) w = 32;
			if (sgn) begin
				hi = (64'sd1 <<< (w - 1)) - 1;
				lo = -hi - 1;
			end else begin
				lo = 0;
				hi = (64'sd1 <<< w) - 1;
			end
			a_nan = vb[30:23] == 8'hFF && vb[22:0] != 0;
			b_nan = scale[30:23] == 8'hFF && scale[22:0] != 0;
			a_inf = vb[30:23] == 8'hFF && vb[22:0] == 0;
			b_inf = scale[30:23] == 8'hFF && scale[22:0] == 0;
			neg = vb[31] ^ scale[31];
			kind = QK_FIN;
			mag = 0;
			if (a_nan || b_nan) begin
				kind = QK_NAN;
			end else if (scale[30:0] == 0) begin
				if (vb[30:0] == 0) kind = QK_NAN;
				else kind = neg ? QK_NEG : QK_POS;
			end else if (a_inf && b_inf) begin
				kind = QK_NAN;
			end else if (a_inf) begin
				kind = neg ? QK_NEG : QK_POS;
			end else if (!b_inf && vb[30:0] != 0) begin
				ma = {1'b0, vb[30:23] != 0, vb[22:0]};
				ea = (vb[30:23] != 0) ? int'(vb[30:23]) - 127 : -126;
				while (!ma[23]) begin
					ma = ma << 1;
					ea--;
				end
				mb = {1'b0, scale[30:23] != 0, scale[22:0]};
				eb = (scale[30:23] != 0) ? int'(scale[30:23]) - 127 : -126;
				while (!mb[23]) begin
					mb = mb << 1;
					eb--;
				end
				e = ea - eb;
				den = longint'(mb);
				if (ma < mb) begin
					num = longint'(ma) << 26;
					e--;
				end else begin
					num = longint'(ma) << 25;
				end
				quo = num / den;
				rm = num % den;
				mant = {1'b0, quo[25:2]};
				rup = quo[1] && (quo[0] || rm != 0 || mant[0]);
				mant = mant + 25'(rup);
				if (mant[24]) begin
					mant = mant >> 1;
					e++;
				end
				if (e >= 40) kind = neg ? QK_NEG : QK_POS;
				else if (e < 0) mag = 0;
				else if (e <= 23) mag = longint'(mant) >> (23 - e);
				else mag = longint'(mant) << (e - 23);
			end
			r.last = last;
			r.clamp = 1'b0;
			if (kind == QK_NAN) begin
				r.qv = 32'd0;
			end else begin
				sum = (neg ? -mag : mag) + longint'(offset);
				if (kind == QK_POS || (kind == QK_FIN && sum > hi)) begin
					sum = hi;
					r.clamp = 1'b1;
				end else if (kind == QK_NEG || sum < lo) begin
					sum = lo;
					r.clamp = 1'b1;
				end
				r.qv = sum[31:0];
			end
			return r;
		endfunction

		function void note_sample(logic [31:0] vb, logic last);
			pending_q.push_back(quantize(vb, last));
		endfunction

		function void check_result(logic [31:0] qv, logic clamp, logic last);
			quant_t x;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected item qv=%h clamp=%b last=%b", $time, qv, clamp, last);
				errors++;
				return;
			end
			x = pending_q.pop_front();
			checked++;
			clamps += int'(clamp);
			if (x.qv !== qv || x.clamp !== clamp || x.last !== last) begin
				$display("%0t: mismatch expected qv=%h clamp=%b last=%b actual qv=%h clamp=%b last=%b",
					$time, x.qv, x.clamp, x.last, qv, clamp, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	quant_scoreboard sb = new();
	bit quiet = 0;
	int sent = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	affine_float_to_int_quantizer uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_tready <= arst_n;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0], m_tlast);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || psel || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 3000) begin
			$display("%0t: timeout", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_sample(logic [31:0] vb, logic last);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= vb;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(vb, last);
		sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] specials[10] = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00000, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
			32'h53800000};
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return specials[$urandom_range(0, 9)];
		if (r < 16) return $urandom;
		return {1'($urandom), 8'($urandom_range(95, 170)), 23'($urandom)};
	endfunction

	qcfg_t phases[11] = '{
		'{32'h3F000000, 32'h00000000, 6'd16, 1'b1},
		'{32'h3DCCCCCD, 32'h00000080, 6'd8, 1'b0},
		'{32'hC0400000, 32'hFFFFFF00, 6'd1, 1'b1},
		'{32'h3F800000, 32'h80000000, 6'd32, 1'b1},
		'{32'h3F800000, 32'h7FFFFFFF, 6'd32, 1'b0},
		'{32'h00000000, 32'h00000005, 6'd0, 1'b0},
		'{32'h80000000, 32'hFFFFFFFB, 6'd63, 1'b1},
		'{32'h7F800000, 32'h00000003, 6'd12, 1'b1},
		'{32'h7FC00000, 32'h00000000, 6'd1, 1'b0},
		'{32'h00000001, 32'h00000000, 6'd31, 1'b1},
		'{32'h3A83126F, 32'h00000007, 6'd24, 1'b0}
	};

	logic [31:0] directed[22] = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
		32'h42FE0000, 32'h43000000, 32'hC3000000, 32'hC3010000, 32'h3F7FFFFF, 32'h3FC00000,
		32'hBFC00000, 32'h42FFFFFF, 32'h7FC00000, 32'hFFFFFFFF, 32'h7F800000, 32'hFF800000,
		32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h80000001, 32'h53800000, 32'hD37FFFFF};

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) send_sample(directed[i], i[0]);
		drain();
		foreach (phases[p]) begin
			write_reg(afq_pkg::REG_SCALE, phases[p].scale);
			write_reg(afq_pkg::REG_OFFSET, phases[p].offset);
			write_reg(afq_pkg::REG_WIDTH, {26'd0, phases[p].width});
			write_reg(afq_pkg::REG_SIGNED, {31'd0, phases[p].sgn});
			if (p == 10) quiet = 1;
			for (int i = 0; i < 160; i++)
				send_sample(pick_value(), $urandom_range(0, 7) == 0);
			drain();
		end
		$display("covered %0d samples over %0d register settings, %0d results checked",
			sent, 12, sb.checked);
		$display("saturated results seen: %0d", sb.clamps);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
